// ===== hw/rtl/dvc_pkg.sv =====
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared widths, state encoding and control and status structs of the distinct value
// counter.
// ----------------------------------------------------------------------------
package dvc_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int DATA_W    = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// control from the sequencer to the tally unit, aligned with read data
	typedef struct packed {
		logic clear;
		logic key_ld;
		logic cmp_en;
		logic cmp_later;
	} tally_ctl_t;

	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic [CNT_W-1:0]  occ;
		logic              later;
	} tally_sts_t;

endpackage

// ===== hw/rtl/distinct_value_counter_core.sv =====
// ----------------------------------------------------------------------------
// distinct_value_counter_core
// Counts the distinct Q16.16 values of a loaded set and how often each occurs.
// ----------------------------------------------------------------------------
// Usage:
// - a request is taken on a clock edge where start is high and busy is low;
//   it carries value and last
// - requests with last low are stored and leave busy low; past 64 stored
//   elements further values are dropped and overflow is set on every result
//   of that report
// - a request with last high (stored too, if there is room) starts the
//   report; busy stays high until the report ends
// - for each index the report reads the element buffer once for the key and
//   then once per stored element, all through its single read port
// - each result is shown for one cycle with result_strobe high, in order of
//   increasing position; the last one has final_res high and distinct_total
//   set, and appears in the first cycle busy is low again
// - the receiver cannot stall; results are never held back
// - after reset the buffer is empty and no report is running
// ----------------------------------------------------------------------------
module distinct_value_counter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [dvc_pkg::DATA_W-1:0] value,
	input  logic                       last,
	output logic                       result_strobe,
	output logic [dvc_pkg::IDX_W-1:0]  position,
	output logic [dvc_pkg::DATA_W-1:0] element,
	output logic [dvc_pkg::CNT_W-1:0]  occurrences,
	output logic [dvc_pkg::CNT_W-1:0]  distinct_total,
	output logic                       final_res,
	output logic                       overflow
);
	import dvc_pkg::*;

	logic              wr_en, rd_en;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	logic [DATA_W-1:0] rd_data;
	tally_ctl_t        tctl;
	tally_sts_t        tsts;

	dvc_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dvc_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tctl),
		.rd_data (rd_data),
		.sts     (tsts)
	);

	dvc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.last           (last),
		.busy           (busy),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.tctl           (tctl),
		.tsts           (tsts),
		.result_strobe  (result_strobe),
		.position       (position),
		.element        (element),
		.occurrences    (occurrences),
		.distinct_total (distinct_total),
		.final_res      (final_res),
		.overflow       (overflow)
	);

endmodule

// ===== hw/rtl/dvc_store.sv =====
// ----------------------------------------------------------------------------
// dvc_store
// Element buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dvc_store (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [dvc_pkg::IDX_W-1:0]  wr_addr,
	input  logic [dvc_pkg::DATA_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [dvc_pkg::IDX_W-1:0]  rd_addr,
	output logic [dvc_pkg::DATA_W-1:0] rd_data
);
	import dvc_pkg::*;

	logic [DATA_W-1:0] mem [MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/dvc_tally.sv =====
// ----------------------------------------------------------------------------
// dvc_tally
// Holds the key under test and counts matches over one scan of the buffer,
// noting whether a match lies at a later index.
// ----------------------------------------------------------------------------
module dvc_tally (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dvc_pkg::tally_ctl_t        ctl,
	input  logic [dvc_pkg::DATA_W-1:0] rd_data,
	output dvc_pkg::tally_sts_t        sts
);
	import dvc_pkg::*;

	logic [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]  occ_q;
	logic              later_q;
	logic              hit;

	assign hit = ctl.cmp_en && (rd_data == key_q);

	always_ff @(posedge clk) begin
		if (ctl.key_ld) begin
			key_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			later_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q   <= '0;
			later_q <= 1'b0;
		end else if (hit) begin
			occ_q <= occ_q + CNT_W'(1);
			if (ctl.cmp_later) begin
				later_q <= 1'b1;
			end
		end
	end

	assign sts.key   = key_q;
	assign sts.occ   = occ_q;
	assign sts.later = later_q;

endmodule

// ===== hw/rtl/dvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvc_ctrl
// Load and report sequencer: stores elements, walks every index against
// the whole buffer and registers the results.
// ----------------------------------------------------------------------------
module dvc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       last,
	output logic                       busy,
	output logic                       wr_en,
	output logic [dvc_pkg::IDX_W-1:0]  wr_addr,
	output logic                       rd_en,
	output logic [dvc_pkg::IDX_W-1:0]  rd_addr,
	output dvc_pkg::tally_ctl_t        tctl,
	input  dvc_pkg::tally_sts_t        tsts,
	output logic                       result_strobe,
	output logic [dvc_pkg::IDX_W-1:0]  position,
	output logic [dvc_pkg::DATA_W-1:0] element,
	output logic [dvc_pkg::CNT_W-1:0]  occurrences,
	output logic [dvc_pkg::CNT_W-1:0]  distinct_total,
	output logic                       final_res,
	output logic                       overflow
);
	import dvc_pkg::*;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  i_q, k_q, last_idx;
	logic [CNT_W-1:0]  fill_q, distinct_q;
	logic              drop_q;
	logic              accept, room;
	logic              key_rd, scan_rd, scan_later, emit, fin;
	logic              key_ld_s1, cmp_en_s1, cmp_later_s1;
	logic              strobe_q;

	assign accept   = start && (state_q == ST_IDLE);
	assign room     = fill_q < CNT_W'(MAX_ITEMS);
	assign last_idx = fill_q[IDX_W-1:0] - IDX_W'(1);
	assign busy     = state_q != ST_IDLE;
	assign wr_en    = accept && room;
	assign wr_addr  = fill_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = k_q;
		key_rd     = 1'b0;
		scan_rd    = 1'b0;
		scan_later = 1'b0;
		emit       = 1'b0;
		fin        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && last) begin
					state_d = ST_KEY;
				end
			end
			ST_KEY: begin
				rd_en   = 1'b1;
				rd_addr = i_q;
				key_rd  = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				rd_en      = 1'b1;
				scan_rd    = 1'b1;
				scan_later = k_q > i_q;
				if (k_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last compare lands this cycle
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit    = !tsts.later;
				fin     = i_q == last_idx;
				state_d = fin ? ST_IDLE : ST_KEY;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign tctl.clear     = key_rd;
	assign tctl.key_ld    = key_ld_s1;
	assign tctl.cmp_en    = cmp_en_s1;
	assign tctl.cmp_later = cmp_later_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ld_s1    <= 1'b0;
			cmp_en_s1    <= 1'b0;
			cmp_later_s1 <= 1'b0;
			i_q          <= '0;
			k_q          <= '0;
			fill_q       <= '0;
			drop_q       <= 1'b0;
			distinct_q   <= '0;
			strobe_q     <= 1'b0;
		end else begin
			key_ld_s1    <= key_rd;
			cmp_en_s1    <= scan_rd;
			cmp_later_s1 <= scan_later;
			strobe_q     <= emit;
			if (accept) begin
				if (room) begin
					fill_q <= fill_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
				if (last) begin
					i_q        <= '0;
					distinct_q <= '0;
				end
			end
			if (key_rd) begin
				k_q <= '0;
			end else if (scan_rd) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (emit) begin
				distinct_q <= distinct_q + CNT_W'(1);
			end
			if (state_q == ST_EMIT) begin
				if (fin) begin
					fill_q <= '0;
					drop_q <= 1'b0;
				end else begin
					i_q <= i_q + IDX_W'(1);
				end
			end
		end
	end

	// result register, loaded only when a result goes out
	always_ff @(posedge clk) begin
		if (emit) begin
			position       <= i_q;
			element        <= tsts.key;
			occurrences    <= tsts.occ;
			distinct_total <= fin ? distinct_q + CNT_W'(1) : '0;
			final_res      <= fin;
			overflow       <= drop_q;
		end
	end

	assign result_strobe = strobe_q;

endmodule

// ===== hw/rtl/dvc_checker.sv =====
// ----------------------------------------------------------------------------
// dvc_checker
// Port-level checks of the distinct value counter, bound to the top level.
// ----------------------------------------------------------------------------
module dvc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       last,
	input logic                       result_strobe,
	input logic [dvc_pkg::CNT_W-1:0]  occurrences,
	input logic [dvc_pkg::CNT_W-1:0]  distinct_total,
	input logic                       final_res
);
	import dvc_pkg::*;

	// a plain element never starts work or a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last |=> !busy && !result_strobe)
		else $error("stored element started work");

	// results ahead of the final one come while the report still runs
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !final_res |-> busy)
		else $error("non-final result outside a report");

	a_total_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && final_res |-> distinct_total != '0)
		else $error("final result without distinct total");

	a_total_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !final_res |-> distinct_total == '0)
		else $error("distinct total on non-final result");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> occurrences != '0)
		else $error("result with zero occurrences");

endmodule

bind distinct_value_counter_core dvc_checker u_dvc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.last           (last),
	.result_strobe  (result_strobe),
	.occurrences    (occurrences),
	.distinct_total (distinct_total),
	.final_res      (final_res)
);

// ===== dv/distinct_value_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// distinct_value_counter_core_tb
// Loads sets of Q16.16 values into the counter and checks every reported
// distinct value, its last position, occurrence count, the distinct total and
// the overflow mark against a predictor kept alongside the driver. Sets range
// from single elements to ones that overrun the 64-entry buffer, with random
// gaps between requests.
// ----------------------------------------------------------------------------
module distinct_value_counter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dvc_pkg::*;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              last;
	} request_t;

	typedef struct {
		logic [IDX_W-1:0]  position;
		logic [DATA_W-1:0] element;
		logic [CNT_W-1:0]  occurrences;
		logic [CNT_W-1:0]  distinct_total;
		logic              final_res;
		logic              overflow;
	} tally_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [DATA_W-1:0] value = '0;
	logic              last = 1'b0;
	logic              result_strobe;
	logic [IDX_W-1:0]  position;
	logic [DATA_W-1:0] element;
	logic [CNT_W-1:0]  occurrences;
	logic [CNT_W-1:0]  distinct_total;
	logic              final_res;
	logic              overflow;

	distinct_value_counter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.last           (last),
		.result_strobe  (result_strobe),
		.position       (position),
		.element        (element),
		.occurrences    (occurrences),
		.distinct_total (distinct_total),
		.final_res      (final_res),
		.overflow       (overflow)
	);

	always #1 clk = ~clk;

	request_t          pending_requests[$];
	tally_t            predicted_tallies[$];
	logic [DATA_W-1:0] set_copy[MAX_ITEMS];
	int                set_fill = 0;
	logic              set_dropped = 1'b0;
	int                accepted_count = 0;
	int                total_requests = 0;
	int                hold_off = 0;
	int                errors = 0;
	request_t          on_port = '{value: '0, last: 1'b0};

	// mirror of the buffer; a last request produces the whole report
	function automatic void tally_request(request_t req);
		tally_t report[$];
		tally_t t;
		int     occ;
		bit     again;
		if (set_fill < MAX_ITEMS) begin
			set_copy[set_fill] = req.value;
			set_fill++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!req.last)
			return;
		for (int i = 0; i < set_fill; i++) begin
			again = 1'b0;
			occ = 0;
			for (int k = 0; k < set_fill; k++) begin
				if (set_copy[k] == set_copy[i]) begin
					occ++;
					if (k > i)
						again = 1'b1;
				end
			end
			if (again)
				continue;
			t.position       = IDX_W'(i);
			t.element        = set_copy[i];
			t.occurrences    = CNT_W'(occ);
			t.distinct_total = '0;
			t.final_res      = 1'b0;
			t.overflow       = set_dropped;
			report.push_back(t);
		end
		if (report.size() > 0) begin
			report[report.size()-1].distinct_total = CNT_W'(report.size());
			report[report.size()-1].final_res      = 1'b1;
		end
		foreach (report[j])
			predicted_tallies.push_back(report[j]);
		set_fill = 0;
		set_dropped = 1'b0;
	endfunction

	function automatic void add_request(logic [DATA_W-1:0] v, logic is_last);
		request_t req;
		req.value = v;
		req.last  = is_last;
		pending_requests.push_back(req);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	// driver: a request leaves the ports once it is taken, then a drawn gap
	always @(posedge clk) begin
		logic     next_start;
		request_t next_req;
		next_start = start;
		next_req = on_port;
		if (arst_n) begin
			if (start && !busy) begin
				tally_request(on_port);
				accepted_count++;
				// alternate stretches of back-to-back requests and gapped ones
				hold_off = ((accepted_count / 40) % 2 == 1) ? 0 : $urandom_range(0, 3);
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (hold_off > 0) begin
					hold_off--;
				end else if (pending_requests.size() > 0) begin
					next_req = pending_requests.pop_front();
					next_start = 1'b1;
				end
			end
		end
		on_port = next_req;
		start <= next_start;
		value <= next_req.value;
		last <= next_req.last;
	end

	// monitor: results cannot be held off, so every strobe is taken
	always @(posedge clk) begin
		tally_t want;
		if (arst_n && result_strobe) begin
			if (predicted_tallies.size() == 0) begin
				$error("unexpected result: position %0d element %h", position, element);
				errors++;
			end else begin
				want = predicted_tallies.pop_front();
				check_field("position", want.position, position);
				check_field("element", want.element, element);
				check_field("occurrences", want.occurrences, occurrences);
				check_field("distinct_total", want.distinct_total, distinct_total);
				check_field("final_res", want.final_res, final_res);
				check_field("overflow", want.overflow, overflow);
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] pool[4];
		int                pool_n;
		int                set_size;
		int                mode;
		int                set_no;
		logic [DATA_W-1:0] v;

		// single element at the positive extreme
		add_request(32'h7FFF_FFFF, 1'b1);
		// extremes with repeats, last occurrences out of order
		add_request(32'h8000_0000, 1'b0);
		add_request(32'hFFFF_FFFF, 1'b0);
		add_request(32'h8000_0000, 1'b0);
		add_request(32'h0000_0000, 1'b0);
		add_request(32'h0001_0000, 1'b0);
		add_request(32'hFFFF_FFFF, 1'b1);
		// one value only
		repeat (3) add_request(32'h0001_0000, 1'b0);
		add_request(32'h0001_0000, 1'b1);
		// alternating bit patterns
		add_request(32'h5555_5555, 1'b0);
		add_request(32'hAAAA_AAAA, 1'b1);

		set_no = 0;
		while (pending_requests.size() < 513) begin
			if (set_no % 10 == 3)
				set_size = MAX_ITEMS + $urandom_range(0, 6);	// full buffer, mostly overrun
			else if (set_no % 10 == 8)
				set_size = $urandom_range(20, MAX_ITEMS - 1);
			else
				set_size = $urandom_range(1, 12);
			mode = $urandom_range(0, 2);
			pool_n = $urandom_range(1, 4);
			for (int p = 0; p < 4; p++)
				pool[p] = $urandom();
			for (int j = 0; j < set_size; j++) begin
				case (mode)
					0: v = pool[$urandom_range(0, pool_n - 1)];
					1: v = $urandom();
					default: begin
						case ($urandom_range(0, 6))
							0: v = 32'h0000_0000;
							1: v = 32'h8000_0000;
							2: v = 32'h7FFF_FFFF;
							3: v = 32'hFFFF_FFFF;
							4: v = 32'h0001_0000;
							5: v = 32'hFFFF_0000;
							default: v = $urandom();
						endcase
					end
				endcase
				add_request(v, j == set_size - 1);
			end
			set_no++;
		end
		total_requests = pending_requests.size();

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_count < total_requests)
			@(posedge clk);
		while (predicted_tallies.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("distinct_value_counter_core: match");
		else
			$display("distinct_value_counter_core: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("distinct_value_counter_core: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dvc_pkg.sv
hw/rtl/dvc_store.sv
hw/rtl/dvc_tally.sv
hw/rtl/dvc_ctrl.sv
hw/rtl/distinct_value_counter_core.sv
hw/rtl/dvc_checker.sv
dv/distinct_value_counter_core_tb.sv
